/* rtl/core/mid_side_stereo_widener_core_macros.svh */
// assertion macros for the mid/side widener core
// included by the controller and datapath; no other dependencies
`ifndef MID_SIDE_STEREO_WIDENER_CORE_MACROS_SVH
`define MID_SIDE_STEREO_WIDENER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MSSW_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MSSW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSSW_ASSERT(label, clk, rst, prop, msg)
`define MSSW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* rtl/core/mssw_pkg.sv */
// shared types, register indexes and constants of the mid/side widener core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mssw_pkg;

  // parameter defaults
  localparam int DELAY_DEPTH_DEFAULT = 1024;
  localparam int SAMPLE_BITS_DEFAULT = 24;

  // configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int DELAY_BITS     = 10;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_GAIN   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_CLAMP   = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIDE_DELAY   = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRESERVE_MIX = CFG_INDEX_BITS'(3);
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRIM_GAIN    = CFG_INDEX_BITS'(4);
  localparam logic [CFG_INDEX_BITS-1:0] REG_MONO_MODE    = CFG_INDEX_BITS'(5);

  // register reset values
  localparam logic [15:0]           WIDTH_GAIN_RESET   = 16'd19661;
  localparam logic [DELAY_BITS-1:0] SIDE_DELAY_RESET   = DELAY_BITS'(72);
  localparam logic [15:0]           PRESERVE_MIX_RESET = 16'd26214;
  localparam logic [14:0]           TRIM_GAIN_RESET    = 15'd4096;

  // gain limits, q2.14 and q1.15
  localparam logic [15:0] WIDTH_MAX      = 16'd32768;
  localparam logic [15:0] WIDTH_SAFE_MAX = 16'd16384;
  localparam logic [15:0] MIX_ONE        = 16'd32768;

  // coefficient operand of the shared multiplier, signed
  localparam int MUL_B_BITS = 17;

  typedef struct packed {
    logic [15:0]           width_gain;
    logic                  gain_clamp;
    logic [DELAY_BITS-1:0] side_delay_samples;
    logic [15:0]           preserve_mix;
    logic [14:0]           trim_gain;
    logic                  mono_mode;
  } cfg_t;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_WIDTH,
    MUL_DIRECT,
    MUL_DELAYED,
    MUL_SUM,
    MUL_DIFF,
    MUL_MONO
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     hist_write;
    logic     hist_read;
    logic     acc_load;
    logic     s_load;
    logic     left_load;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/mid_side_stereo_widener_core.sv */
// mid/side stereo widener core, top level with configuration registers
// stereo: one shared multiplier forms five products per request; mono: a single product
// a new request is taken only after the previous result has been loaded to the output
// output stalls hold the result back; synchronous reset restores register defaults and empties
//   the delay line through a fill count, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module mid_side_stereo_widener_core #(
  parameter int DELAY_DEPTH = mssw_pkg::DELAY_DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = mssw_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [mssw_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [mssw_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]         left_in,
  input  wire logic signed [SAMPLE_BITS-1:0]         right_in,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [SAMPLE_BITS-1:0]              left_out,
  output logic signed [SAMPLE_BITS-1:0]              right_out
);

  mssw_pkg::cfg_t cfg;
  mssw_pkg::cmd_t cmd;
  mssw_pkg::sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_gain         <= mssw_pkg::WIDTH_GAIN_RESET;
      cfg.gain_clamp         <= 1'b0;
      cfg.side_delay_samples <= mssw_pkg::SIDE_DELAY_RESET;
      cfg.preserve_mix       <= mssw_pkg::PRESERVE_MIX_RESET;
      cfg.trim_gain          <= mssw_pkg::TRIM_GAIN_RESET;
      cfg.mono_mode          <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mssw_pkg::REG_WIDTH_GAIN:   cfg.width_gain <= cfg_data[15:0];
        mssw_pkg::REG_GAIN_CLAMP:   cfg.gain_clamp <= cfg_data[0];
        mssw_pkg::REG_SIDE_DELAY: begin
          cfg.side_delay_samples <= cfg_data[mssw_pkg::DELAY_BITS-1:0];
        end
        mssw_pkg::REG_PRESERVE_MIX: cfg.preserve_mix <= cfg_data[15:0];
        mssw_pkg::REG_TRIM_GAIN:    cfg.trim_gain <= cfg_data[14:0];
        mssw_pkg::REG_MONO_MODE:    cfg.mono_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  mssw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mono     (cfg.mono_mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and delay line
  mssw_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .left_in   (left_in),
    .right_in  (right_in),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .left_out  (left_out),
    .right_out (right_out)
  );

endmodule

`default_nettype wire

/* rtl/core/mssw_ctrl.sv */
// sequencer of the mid/side widener: steps the shared multiplier and delay line
// depends on mssw_pkg and the core assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "mid_side_stereo_widener_core_macros.svh"

module mssw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          mono,
  input  wire mssw_pkg::sts_t sts,
  output mssw_pkg::cmd_t     cmd
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_WID  = 10'b00_0000_0010,
    ST_DIR  = 10'b00_0000_0100,
    ST_RD   = 10'b00_0000_1000,
    ST_MIX  = 10'b00_0001_0000,
    ST_SUM  = 10'b00_0010_0000,
    ST_OUTL = 10'b00_0100_0000,
    ST_OUTR = 10'b00_1000_0000,
    ST_MONO = 10'b01_0000_0000,
    ST_DONE = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // a request is taken only while idle
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = mssw_pkg::MUL_WIDTH;
    unique case (state)
      ST_IDLE: begin
        cmd.load_in = accept;
        if (accept) begin
          state_next = mono ? ST_MONO : ST_WID;
        end
      end
      ST_WID: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mssw_pkg::MUL_WIDTH;
        state_next  = ST_DIR;
      end
      ST_DIR: begin
        cmd.hist_write = 1'b1;
        state_next     = ST_RD;
      end
      ST_RD: begin
        cmd.hist_read = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = mssw_pkg::MUL_DIRECT;
        state_next    = ST_MIX;
      end
      ST_MIX: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = mssw_pkg::MUL_DELAYED;
        state_next   = ST_SUM;
      end
      ST_SUM: begin
        cmd.s_load = 1'b1;
        state_next = ST_OUTL;
      end
      ST_OUTL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mssw_pkg::MUL_SUM;
        state_next  = ST_OUTR;
      end
      ST_OUTR: begin
        cmd.left_load = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = mssw_pkg::MUL_DIFF;
        state_next    = ST_DONE;
      end
      ST_MONO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mssw_pkg::MUL_MONO;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // checks
  `MSSW_ASSERT(a_accept_blocks, clk, rst, accept |=> in_stall, "second request taken while busy")
  `MSSW_ASSERT(a_read_after_write, clk, rst, (state == ST_RD) |-> ($past(state) == ST_DIR), "history read without preceding write")
  `MSSW_ASSERT(a_done_holds, clk, rst, (state == ST_DONE && !sts.out_free) |=> (state == ST_DONE), "result dropped while output busy")

endmodule

`default_nettype wire

/* rtl/core/mssw_datapath.sv */
// datapath of the mid/side widener: shared multiplier, side delay line, output register
// depends on mssw_pkg and the core assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "mid_side_stereo_widener_core_macros.svh"

module mssw_datapath #(
  parameter int DELAY_DEPTH = mssw_pkg::DELAY_DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = mssw_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire mssw_pkg::cfg_t          cfg,
  input  wire mssw_pkg::cmd_t          cmd,
  output mssw_pkg::sts_t               sts,
  input  wire logic signed [SAMPLE_BITS-1:0] left_in,
  input  wire logic signed [SAMPLE_BITS-1:0] right_in,
  input  wire logic                    out_stall,
  output logic                         out_valid,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out
);

  localparam int SB = SAMPLE_BITS;
  localparam int HW = SB + 1;                    // stored side width
  localparam int AW = SB + 3;                    // sample operand width
  localparam int BW = mssw_pkg::MUL_B_BITS;      // coefficient operand width
  localparam int PW = AW + BW;                   // product width
  localparam int AD = $clog2(DELAY_DEPTH);
  localparam int CW = (AD + 1 > mssw_pkg::DELAY_BITS) ? AD + 1 : mssw_pkg::DELAY_BITS;

  localparam logic signed [PW-1:0] HALF12 = PW'(2048);
  localparam logic signed [PW-1:0] HALF14 = PW'(8192);
  localparam logic signed [PW:0]   HALF15 = (PW + 1)'(16384);

  localparam logic signed [PW-1:0] HIST_MAX = {{(PW-HW+1){1'b0}}, {(HW-1){1'b1}}};
  localparam logic signed [PW-1:0] HIST_MIN = {{(PW-HW+1){1'b1}}, {(HW-1){1'b0}}};
  localparam logic signed [PW-1:0] OUT_MAX  = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [PW-1:0] OUT_MIN  = {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};

  localparam logic [AD:0]   DEPTH_A  = (AD + 1)'(DELAY_DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DELAY_DEPTH);
  localparam logic [AD-1:0] WP_LAST  = AD'(DELAY_DEPTH - 1);
  localparam logic [AD:0]   FILL_MAX = (AD + 1)'(DELAY_DEPTH);

  // request capture
  logic signed [SB:0]   pair_sum;
  logic signed [SB:0]   pair_diff;
  logic signed [SB-1:0] mid_q;
  logic signed [SB-1:0] side_q;
  logic signed [SB-1:0] mono_q;

  // arithmetic registers
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] acc_q;
  logic signed [HW-1:0] direct_q;
  logic signed [SB+1:0] s_q;
  logic signed [SB-1:0] left_res_q;

  // delay line
  logic [HW-1:0] hist [DELAY_DEPTH];
  logic [HW-1:0] rdata_q;
  logic          rd_valid_q;
  logic [AD-1:0] wp_q;
  logic [AD:0]   fill_q;
  logic          out_valid_q;

  // combinational
  logic [15:0]          width_limit;
  logic [15:0]          w_eff;
  logic [15:0]          p_eff;
  logic [15:0]          q_eff;
  logic signed [AW-1:0] a_op;
  logic signed [BW-1:0] b_op;
  logic signed [AW-1:0] mid_ext;
  logic signed [AW-1:0] s_ext;
  logic signed [HW-1:0] hist_val;
  logic signed [PW-1:0] r14;
  logic signed [PW-1:0] r12;
  logic signed [HW-1:0] direct_val;
  logic signed [SB-1:0] res_val;
  logic signed [PW:0]   mix_sum;
  logic signed [PW:0]   mix_shift;
  logic [CW-1:0]        delay_ext;
  logic [CW-1:0]        delay_clamp;
  logic [AD-1:0]        delay_eff;
  logic [AD:0]          rd_full;
  logic [AD-1:0]        rd_addr;

  // mid and side, floor of half sum and half difference
  assign pair_sum  = {left_in[SB-1], left_in} + {right_in[SB-1], right_in};
  assign pair_diff = {left_in[SB-1], left_in} - {right_in[SB-1], right_in};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mid_q  <= pair_sum[SB:1];
      side_q <= pair_diff[SB:1];
      mono_q <= left_in;
    end
  end

  // effective gains
  assign width_limit = cfg.gain_clamp ? mssw_pkg::WIDTH_SAFE_MAX : mssw_pkg::WIDTH_MAX;
  assign w_eff       = (cfg.width_gain > width_limit) ? width_limit : cfg.width_gain;
  assign p_eff       = (cfg.preserve_mix > mssw_pkg::MIX_ONE) ? mssw_pkg::MIX_ONE
                                                              : cfg.preserve_mix;
  assign q_eff       = mssw_pkg::MIX_ONE - p_eff;

  // operand selection
  assign mid_ext  = {{3{mid_q[SB-1]}}, mid_q};
  assign s_ext    = {s_q[SB+1], s_q};
  assign hist_val = rd_valid_q ? rdata_q : '0;

  always_comb begin
    case (cmd.mul_sel)
      mssw_pkg::MUL_WIDTH: begin
        a_op = {{(AW-SB){side_q[SB-1]}}, side_q};
        b_op = {1'b0, w_eff};
      end
      mssw_pkg::MUL_DIRECT: begin
        a_op = {{(AW-HW){direct_q[HW-1]}}, direct_q};
        b_op = {1'b0, p_eff};
      end
      mssw_pkg::MUL_DELAYED: begin
        a_op = {{(AW-HW){hist_val[HW-1]}}, hist_val};
        b_op = {1'b0, q_eff};
      end
      mssw_pkg::MUL_SUM: begin
        a_op = mid_ext + s_ext;
        b_op = {2'b00, cfg.trim_gain};
      end
      mssw_pkg::MUL_DIFF: begin
        a_op = mid_ext - s_ext;
        b_op = {2'b00, cfg.trim_gain};
      end
      mssw_pkg::MUL_MONO: begin
        a_op = {{(AW-SB){mono_q[SB-1]}}, mono_q};
        b_op = {2'b00, cfg.trim_gain};
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_q <= a_op * b_op;
    end
  end

  // round half up and saturate the scaled side
  assign r14 = (prod_q + HALF14) >>> 14;
  always_comb begin
    if (r14 > HIST_MAX) begin
      direct_val = HIST_MAX[HW-1:0];
    end else if (r14 < HIST_MIN) begin
      direct_val = HIST_MIN[HW-1:0];
    end else begin
      direct_val = r14[HW-1:0];
    end
  end

  // blend of direct and delayed side
  assign mix_sum   = {acc_q[PW-1], acc_q} + {prod_q[PW-1], prod_q} + HALF15;
  assign mix_shift = mix_sum >>> 15;

  // output rounding and saturation
  assign r12 = (prod_q + HALF12) >>> 12;
  always_comb begin
    if (r12 > OUT_MAX) begin
      res_val = OUT_MAX[SB-1:0];
    end else if (r12 < OUT_MIN) begin
      res_val = OUT_MIN[SB-1:0];
    end else begin
      res_val = r12[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_write) begin
      direct_q <= direct_val;
    end
    if (cmd.acc_load) begin
      acc_q <= prod_q;
    end
    if (cmd.s_load) begin
      s_q <= mix_shift[SB+1:0];
    end
    if (cmd.left_load) begin
      left_res_q <= res_val;
    end
  end

  // read address, delay clamped below the depth
  assign delay_ext   = CW'(cfg.side_delay_samples);
  assign delay_clamp = (delay_ext >= DEPTH_C) ? DEPTH_C - CW'(1) : delay_ext;
  assign delay_eff   = delay_clamp[AD-1:0];
  assign rd_full     = {1'b0, wp_q} + DEPTH_A - {1'b0, delay_eff};
  assign rd_addr     = (rd_full >= DEPTH_A) ? AD'(rd_full - DEPTH_A) : rd_full[AD-1:0];

  // delay line memory
  always_ff @(posedge clk) begin
    if (cmd.hist_write) begin
      hist[wp_q] <= direct_val;
    end
    if (cmd.hist_read) begin
      rdata_q    <= hist[rd_addr];
      rd_valid_q <= ({1'b0, rd_addr} < fill_q);
    end
  end

  // write position and fill count, entries past the fill read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else begin
      if (cmd.hist_write && fill_q != FILL_MAX) begin
        fill_q <= fill_q + (AD + 1)'(1);
      end
      if (cmd.hist_read) begin
        wp_q <= (wp_q == WP_LAST) ? '0 : wp_q + AD'(1);
      end
    end
  end

  // output register
  assign sts.out_free = !out_valid_q || !out_stall;
  assign out_valid    = out_valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      left_out  <= cfg.mono_mode ? res_val : left_res_q;
      right_out <= cfg.mono_mode ? '0 : res_val;
    end
  end

  // checks
  `MSSW_ASSERT(a_load_shows, clk, rst, cmd.out_load |=> out_valid_q, "loaded result not presented")
  `MSSW_ASSERT(a_wp_moves, clk, rst, cmd.hist_read |=> (wp_q != $past(wp_q)), "write position did not advance")
  `MSSW_ASSERT_ALWAYS(a_fill_bound, clk, rst || (fill_q <= FILL_MAX), "fill count beyond delay depth")

endmodule

`default_nettype wire
